@@ hdl/u8sd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

    localparam int BYTE_W       = 8;
    localparam int CP_W         = 31;
    localparam int CHAR_INDEX_W = 16;
    // Width of the running code point counter; it saturates at all ones.
    localparam int INDEX_WIDTH  = 16;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } byte_item_t;

endpackage

`default_nettype wire

@@ hdl/u8sd_input_stage.sv @@
// Input register stage: holds one accepted byte until the decode core takes it.
`default_nettype none

module u8sd_input_stage
    import u8sd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic              end_of_text,
    input  wire logic              advance,
    output logic                   item_valid,
    output byte_item_t             item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset; load only on a transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.text_byte   <= text_byte;
            item_reg.end_of_text <= end_of_text;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ hdl/u8sd_decode_core.sv @@
// Decode core: sequence state, code point assembly and the result register.
`default_nettype none

module u8sd_decode_core
    import u8sd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    input  wire byte_item_t              item,
    output logic                         advance,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [CP_W-1:0]              char_value,
    output logic [CHAR_INDEX_W-1:0]      char_index,
    output logic [1:0]                   status,
    output logic                         last_result
);

    logic [2:0]             pending_reg;
    logic [2:0]             pending_next;
    logic [CP_W-1:0]        partial_reg;
    logic [CP_W-1:0]        partial_next;
    logic [INDEX_WIDTH-1:0] count_reg;
    logic [INDEX_WIDTH-1:0] count_next;

    logic                    out_valid_reg;
    logic [CP_W-1:0]         char_value_reg;
    logic [CHAR_INDEX_W-1:0] char_index_reg;
    status_t                 status_reg;
    logic                    last_reg;

    logic                    emit;
    logic [CP_W-1:0]         emit_value;
    status_t                 emit_status;
    logic                    emit_last;
    logic [CHAR_INDEX_W-1:0] index_out;

    logic [2:0]      ones;
    logic [6:0]      lead_bits;
    logic [4:0]      lead_shift;
    logic [4:0]      cont_shift;
    logic [CP_W-1:0] lead_value;
    logic [CP_W-1:0] cont_value;
    logic            take;

    function automatic logic [2:0] count_lead_ones(input logic [BYTE_W-1:0] b);
        logic [2:0] n;
        begin
            n = 3'd7;
            // the highest zero bit wins, so scan upward
            for (int i = 0; i <= 6; i++)
            begin
                if (!b[i + 1])
                begin
                    n = 3'(6 - i);
                end
            end
            return n;
        end
    endfunction

    // Result register frees when empty or when its result transfers.
    assign advance = !out_valid_reg || !out_stall;
    assign take    = item_valid && advance;

    assign ones       = count_lead_ones(item.text_byte);
    assign lead_bits  = item.text_byte[6:0] & (7'h7F >> ones);
    assign lead_shift = {2'b00, ones - 3'd1} * 5'd6;
    assign cont_shift = {2'b00, pending_reg - 3'd1} * 5'd6;
    assign lead_value = {{(CP_W - 7){1'b0}}, lead_bits} << lead_shift;
    assign cont_value = partial_reg
                      | ({{(CP_W - 6){1'b0}}, item.text_byte[5:0]} << cont_shift);

    generate
        if (INDEX_WIDTH >= CHAR_INDEX_W)
        begin : g_idx_trunc
            assign index_out = count_reg[CHAR_INDEX_W-1:0];
        end
        else
        begin : g_idx_ext
            assign index_out = {{(CHAR_INDEX_W - INDEX_WIDTH){1'b0}}, count_reg};
        end
    endgenerate

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        emit_value   = '0;
        emit_status  = ST_VALID;
        emit_last    = item.end_of_text;

        if (pending_reg != 3'd0)
        begin
            pending_next = pending_reg - 3'd1;
            if (pending_reg == 3'd1)
            begin
                emit         = 1'b1;
                emit_value   = cont_value;
                partial_next = '0;
            end
            else
            begin
                partial_next = cont_value;
                if (item.end_of_text)
                begin
                    emit        = 1'b1;
                    emit_value  = cont_value;
                    emit_status = ST_TRUNC;
                end
            end
        end
        else
        begin
            case (ones)
                3'd0:
                begin
                    emit       = 1'b1;
                    emit_value = {{(CP_W - 7){1'b0}}, item.text_byte[6:0]};
                end
                3'd1, 3'd7:
                begin
                    emit        = 1'b1;
                    emit_value  = {{(CP_W - 7){1'b0}}, item.text_byte[6:0]};
                    emit_status = ST_INVALID;
                end
                default:
                begin
                    partial_next = lead_value;
                    pending_next = ones - 3'd1;
                    if (item.end_of_text)
                    begin
                        emit        = 1'b1;
                        emit_value  = lead_value;
                        emit_status = ST_TRUNC;
                    end
                end
            endcase
        end

        // End of string clears everything; otherwise count the result, saturating.
        if (emit)
        begin
            if (emit_last)
            begin
                pending_next = '0;
                partial_next = '0;
                count_next   = '0;
            end
            else if (count_reg != {INDEX_WIDTH{1'b1}})
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            partial_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                count_reg   <= count_next;
            end
            if (advance)
            begin
                out_valid_reg <= take && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            char_value_reg <= emit_value;
            char_index_reg <= index_out;
            status_reg     <= emit_status;
            last_reg       <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_value  = char_value_reg;
    assign char_index  = char_index_reg;
    assign status      = status_reg;
    assign last_result = last_reg;

endmodule

`default_nettype wire

@@ hdl/utf8_stream_decoder_unit.sv @@
// Top level of the UTF-8 stream decoder: input stage and decode core.
//
// Bytes enter on the input channel (in_valid / in_stall, text_byte,
// end_of_text), one per transfer; set end_of_text on the last byte of a string.
// Each finished sequence of 1 to 6 bytes leaves on the output channel
// (out_valid / out_stall) as char_value, its char_index within the string,
// a status (valid, invalid lead or stray continuation, truncated) and
// last_result, set for the final result of a string.
// Throughput is one byte per cycle while the output is not stalled: the sequence
// state is a single register loop updated by combinational decode logic.
// A byte lands in the input register at its transfer edge and its result, if
// any, is written from there into the output register once that register frees.
// A stalled result holds in the output register while the input register
// still takes one more byte; in_stall rises only when both are full.
// Reset clears the sequence state, the code point counter and both valid
// flags; the first byte after reset starts a new string.
`default_nettype none

module utf8_stream_decoder_unit
    import u8sd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [BYTE_W-1:0]       text_byte,
    input  wire logic                    end_of_text,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [CP_W-1:0]              char_value,
    output logic [CHAR_INDEX_W-1:0]      char_index,
    output logic [1:0]                   status,
    output logic                         last_result
);

    logic       advance;
    logic       item_valid;
    byte_item_t item;

    u8sd_input_stage u_input_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    u8sd_decode_core u_decode_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_value  (char_value),
        .char_index  (char_index),
        .status      (status),
        .last_result (last_result)
    );

endmodule

`default_nettype wire

@@ hdl/u8sd_checker.sv @@
// Port-level checks for the UTF-8 stream decoder and their bind.
`default_nettype none

module u8sd_checker
    import u8sd_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_stall,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [CP_W-1:0]         char_value,
    input wire logic [CHAR_INDEX_W-1:0] char_index,
    input wire logic [1:0]              status,
    input wire logic                    last_result
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_value)
            && $stable(char_index) && $stable(status) && $stable(last_result))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_VALID || status == ST_INVALID || status == ST_TRUNC))
        else $error("status code out of range");

    // Truncation is only reported at the end of a string.
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TRUNC |-> last_result)
        else $error("truncated result without end of string");

    a_invalid_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INVALID |-> char_value[CP_W-1:7] == '0)
        else $error("invalid byte result wider than 7 bits");

    // An empty output register never stalls the input.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_checker (.*);

`default_nettype wire
